// File: rtl/core/acs_pkg.sv
`default_nettype none
package acs_pkg;

  // Instruction and datapath widths
  localparam int INST_W = 8;
  localparam int ARG_W  = 4;
  localparam int PC_W   = 16;
  localparam int DATA_W = 8;
  localparam int FLAG_W = 7;
  localparam int MADDR_W = 15;

  // Default depth of the decode-to-execute queue
  localparam int QUEUE_DEPTH_DEF = 2;

  // Opcodes (upper nibble of the instruction byte)
  localparam logic [3:0] OPC_NOP     = 4'd0;
  localparam logic [3:0] OPC_LOADLO  = 4'd1;
  localparam logic [3:0] OPC_LOADHI  = 4'd2;
  localparam logic [3:0] OPC_MOVTO   = 4'd3;
  localparam logic [3:0] OPC_MOVFROM = 4'd4;
  localparam logic [3:0] OPC_ADD     = 4'd5;
  localparam logic [3:0] OPC_SUB     = 4'd6;
  localparam logic [3:0] OPC_SPARE_7 = 4'd7;
  localparam logic [3:0] OPC_SHR     = 4'd8;
  localparam logic [3:0] OPC_AND     = 4'd9;
  localparam logic [3:0] OPC_OR      = 4'd10;
  localparam logic [3:0] OPC_JUMP    = 4'd11;
  localparam logic [3:0] OPC_STORE   = 4'd12;
  localparam logic [3:0] OPC_SPARE_D = 4'd13;
  localparam logic [3:0] OPC_SPARE_E = 4'd14;
  localparam logic [3:0] OPC_SPARE_F = 4'd15;

  // Condition flag bit positions
  localparam int F_EQ    = 0;
  localparam int F_LT    = 1;
  localparam int F_GT    = 2;
  localparam int F_CARRY = 3;
  localparam int F_NZ    = 5;
  localparam int F_SHIFT = 6;

  // LED latch addresses
  localparam logic [PC_W-1:0] LED_COL_ADDR   = 16'h8000;
  localparam logic [PC_W-1:0] LED_ROW_ADDR   = 16'h8001;
  localparam logic [PC_W-1:0] LED_COLOR_ADDR = 16'h8002;

  // Instruction class produced by the front end
  typedef enum logic [2:0] {
    CLS_NOP,
    CLS_LOADLO,
    CLS_LOADHI,
    CLS_MOVTO,
    CLS_MOVFROM,
    CLS_ALU,
    CLS_JUMP,
    CLS_STORE
  } cls_t;

  // ALU operation for CLS_ALU
  typedef enum logic [2:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_SHR,
    ALU_AND,
    ALU_OR
  } alu_t;

  // Decoded instruction carried through the queue
  typedef struct packed {
    cls_t             cls;
    alu_t             alu;
    logic [ARG_W-1:0] arg;
  } dec_t;

endpackage
`default_nettype wire

// File: rtl/core/acs_decode.sv
`default_nettype none
module acs_decode (
  input  wire logic [acs_pkg::INST_W-1:0] instruction,
  output acs_pkg::dec_t                   dec
);
  import acs_pkg::*;

  logic [3:0] opc;

  assign opc = instruction[INST_W-1:ARG_W];

  // Classify opcode; unused and expansion codes fall to nop
  always_comb begin
    dec.arg = instruction[ARG_W-1:0];
    dec.alu = ALU_ADD;
    dec.cls = CLS_NOP;
    case (opc)
      OPC_NOP:     dec.cls = CLS_NOP;
      OPC_LOADLO:  dec.cls = CLS_LOADLO;
      OPC_LOADHI:  dec.cls = CLS_LOADHI;
      OPC_MOVTO:   dec.cls = CLS_MOVTO;
      OPC_MOVFROM: dec.cls = CLS_MOVFROM;
      OPC_ADD: begin
        dec.cls = CLS_ALU;
        dec.alu = ALU_ADD;
      end
      OPC_SUB: begin
        dec.cls = CLS_ALU;
        dec.alu = ALU_SUB;
      end
      OPC_SHR: begin
        dec.cls = CLS_ALU;
        dec.alu = ALU_SHR;
      end
      OPC_AND: begin
        dec.cls = CLS_ALU;
        dec.alu = ALU_AND;
      end
      OPC_OR: begin
        dec.cls = CLS_ALU;
        dec.alu = ALU_OR;
      end
      OPC_JUMP:    dec.cls = CLS_JUMP;
      OPC_STORE:   dec.cls = CLS_STORE;
      default:     dec.cls = CLS_NOP;
    endcase
  end

endmodule
`default_nettype wire

// File: rtl/core/acs_queue.sv
`default_nettype none
module acs_queue #(
  parameter int DEPTH = acs_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push_valid,
  output logic               push_ready,
  input  acs_pkg::dec_t      push_data,
  output logic               pop_valid,
  input  wire logic          pop_ready,
  output acs_pkg::dec_t      pop_data
);
  import acs_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  dec_t          mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          push, pop;

  assign push_ready = (count_r != CW'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  // Pointer and occupancy update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage, no reset needed
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("queue occupancy above depth");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0 || count_r == CW'(DEPTH)) |-> (wr_ptr_r == rd_ptr_r))
    else $error("queue pointers disagree with occupancy");

  a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (count_r == $past(count_r) + 1'b1))
    else $error("queue count missed a push");

endmodule
`default_nettype wire

// File: rtl/core/acs_exec.sv
`default_nettype none
module acs_exec (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  // decoded instruction from queue
  input  wire logic                         dec_valid,
  output logic                              dec_ready,
  input  acs_pkg::dec_t                     dec,
  // program length register
  input  wire logic [acs_pkg::PC_W-1:0]     program_length,
  // result channel
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [acs_pkg::PC_W-1:0]          out_next_pc,
  output logic [acs_pkg::DATA_W-1:0]        out_accumulator,
  output logic [acs_pkg::FLAG_W-1:0]        out_flag_bits,
  output logic                              out_mem_write,
  output logic [acs_pkg::MADDR_W-1:0]       out_mem_addr,
  output logic [acs_pkg::DATA_W-1:0]        out_mem_data,
  output logic                              out_led_write,
  output logic [acs_pkg::DATA_W-1:0]        out_led_column,
  output logic [acs_pkg::DATA_W-1:0]        out_led_row,
  output logic [acs_pkg::DATA_W-1:0]        out_led_color,
  output logic                              out_halted
);
  import acs_pkg::*;

  // Architectural state
  logic [PC_W-1:0]   pc_r, pc_nxt;
  logic [DATA_W-1:0] rf_r [16];
  logic [FLAG_W-1:0] flags_r, flags_nxt;
  logic [DATA_W-1:0] col_r, col_nxt;
  logic [DATA_W-1:0] row_r, row_nxt;
  logic [DATA_W-1:0] color_r, color_nxt;

  // Result register
  logic               out_valid_r;
  logic [PC_W-1:0]    out_next_pc_r;
  logic [DATA_W-1:0]  out_acc_r;
  logic [FLAG_W-1:0]  out_flags_r;
  logic               out_mem_write_r, out_mem_write_nxt;
  logic [MADDR_W-1:0] out_mem_addr_r, out_mem_addr_nxt;
  logic [DATA_W-1:0]  out_mem_data_r, out_mem_data_nxt;
  logic               out_led_write_r, out_led_write_nxt;
  logic [DATA_W-1:0]  out_led_col_r, out_led_col_nxt;
  logic [DATA_W-1:0]  out_led_row_r, out_led_row_nxt;
  logic [DATA_W-1:0]  out_led_color_r, out_led_color_nxt;

  logic              pop;
  logic [DATA_W-1:0] acc, other, acc_nxt;
  logic [PC_W-1:0]   addr;
  logic [DATA_W:0]   sum9;
  logic              lt, eq;
  logic [FLAG_W-1:0] cmp_flags;
  logic              rf_we;
  logic [ARG_W-1:0]  rf_waddr;
  logic [DATA_W-1:0] rf_wdata;
  logic              jump_take;

  // Pop when the result slot is free or being drained
  assign dec_ready = !out_valid_r || out_ready;
  assign pop       = dec_valid && dec_ready;

  // Operand read
  assign acc   = rf_r[0];
  assign other = rf_r[dec.arg];
  assign addr  = {rf_r[1], acc};
  assign sum9  = {1'b0, acc} + {1'b0, other};
  assign lt    = acc < other;
  assign eq    = acc == other;
  assign jump_take = ((dec.arg & flags_r[ARG_W-1:0]) == dec.arg);

  // Compare flags shared by every ALU op
  always_comb begin
    cmp_flags        = '0;
    cmp_flags[F_LT]  = lt;
    cmp_flags[F_EQ]  = eq;
    cmp_flags[F_GT]  = !lt && !eq;
    cmp_flags[F_NZ]  = (acc != '0);
  end

  // Execute
  always_comb begin
    pc_nxt            = pc_r + 1'b1;
    flags_nxt         = flags_r;
    acc_nxt           = acc;
    rf_we             = 1'b0;
    rf_waddr          = '0;
    rf_wdata          = acc;
    col_nxt           = col_r;
    row_nxt           = row_r;
    color_nxt         = color_r;
    out_mem_write_nxt = 1'b0;
    out_mem_addr_nxt  = '0;
    out_mem_data_nxt  = '0;
    out_led_write_nxt = 1'b0;
    out_led_col_nxt   = '0;
    out_led_row_nxt   = '0;
    out_led_color_nxt = '0;
    case (dec.cls)
      CLS_LOADLO:  acc_nxt = {acc[DATA_W-1:ARG_W], dec.arg};
      CLS_LOADHI:  acc_nxt = {dec.arg, acc[ARG_W-1:0]};
      CLS_MOVTO: begin
        rf_we    = 1'b1;
        rf_waddr = dec.arg;
        rf_wdata = acc;
      end
      CLS_MOVFROM: acc_nxt = other;
      CLS_ALU: begin
        flags_nxt = cmp_flags;
        case (dec.alu)
          ALU_ADD: begin
            acc_nxt            = sum9[DATA_W-1:0];
            flags_nxt[F_CARRY] = sum9[DATA_W];
          end
          ALU_SUB: acc_nxt = acc - other;
          ALU_SHR: begin
            acc_nxt            = acc >> 1;
            flags_nxt[F_SHIFT] = acc[0];
          end
          ALU_AND: acc_nxt = acc & other;
          ALU_OR:  acc_nxt = acc | other;
          default: acc_nxt = acc;
        endcase
      end
      CLS_JUMP: begin
        if (jump_take) begin
          pc_nxt = addr;
        end
      end
      CLS_STORE: begin
        if (!addr[PC_W-1]) begin
          out_mem_write_nxt = 1'b1;
          out_mem_addr_nxt  = addr[MADDR_W-1:0];
          out_mem_data_nxt  = other;
        end else begin
          if (addr == LED_COL_ADDR) begin
            col_nxt = other;
          end else if (addr == LED_ROW_ADDR) begin
            row_nxt = other;
          end else if (addr == LED_COLOR_ADDR) begin
            color_nxt = other;
          end
          // full triple: issue and clear
          if (col_nxt != '0 && row_nxt != '0 && color_nxt != '0) begin
            out_led_write_nxt = 1'b1;
            out_led_col_nxt   = col_nxt;
            out_led_row_nxt   = row_nxt;
            out_led_color_nxt = color_nxt;
            col_nxt           = '0;
            row_nxt           = '0;
            color_nxt         = '0;
          end
        end
      end
      default: pc_nxt = pc_r + 1'b1;
    endcase
  end

  // State update on each executed instruction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r    <= '0;
      flags_r <= '0;
      col_r   <= '0;
      row_r   <= '0;
      color_r <= '0;
      for (int i = 0; i < 16; i++) begin
        rf_r[i] <= '0;
      end
    end else if (pop) begin
      pc_r    <= pc_nxt;
      flags_r <= flags_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      color_r <= color_nxt;
      if (rf_we) begin
        rf_r[rf_waddr] <= rf_wdata;
      end else begin
        rf_r[0] <= acc_nxt;
      end
    end
  end

  // Result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (pop) begin
      out_next_pc_r   <= pc_nxt;
      out_acc_r       <= rf_we ? acc : acc_nxt;
      out_flags_r     <= flags_nxt;
      out_mem_write_r <= out_mem_write_nxt;
      out_mem_addr_r  <= out_mem_addr_nxt;
      out_mem_data_r  <= out_mem_data_nxt;
      out_led_write_r <= out_led_write_nxt;
      out_led_col_r   <= out_led_col_nxt;
      out_led_row_r   <= out_led_row_nxt;
      out_led_color_r <= out_led_color_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_next_pc     = out_next_pc_r;
  assign out_accumulator = out_acc_r;
  assign out_flag_bits   = out_flags_r;
  assign out_mem_write   = out_mem_write_r;
  assign out_mem_addr    = out_mem_addr_r;
  assign out_mem_data    = out_mem_data_r;
  assign out_led_write   = out_led_write_r;
  assign out_led_column  = out_led_col_r;
  assign out_led_row     = out_led_row_r;
  assign out_led_color   = out_led_color_r;
  assign out_halted      = (out_next_pc_r >= program_length);

  a_no_dual_write: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_mem_write_r && out_led_write_r))
    else $error("memory and LED write in one result");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !pop)
    else $error("executed into a stalled result slot");

  a_led_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && out_led_write_nxt) |=> (col_r == '0 && row_r == '0 && color_r == '0))
    else $error("LED latches not cleared after issue");

  a_flag_bit4: assert property (@(posedge clk) disable iff (!rst_n)
    flags_r[4] == 1'b0)
    else $error("unused flag bit set");

endmodule
`default_nettype wire

// File: rtl/core/accumulator_cpu_execute_step_core.sv
`default_nettype none
// Channel   Ports                                   Direction  Transfer
// in        in_valid/in_ready, in_instruction       input      valid && ready
// out       out_valid/out_ready, out_* result       output     valid && ready
// cfg       cfg_valid/cfg_ready, cfg_program_length input      valid && ready
//
// One instruction per cycle sustained while the output is not stalled; an input
// transfer is registered in the queue and then in the execute result register.
// The execute stage reads and writes the register file in the same cycle, so
// throughput is bound by that execute loop.
// Synchronous active-low reset clears pc, registers, flags, LED latches and
// program length; cfg_ready is always high.
// A stalled output holds execution; the front keeps accepting until the
// queue is full.
module accumulator_cpu_execute_step_core #(
  parameter int QUEUE_DEPTH = acs_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [acs_pkg::INST_W-1:0]   in_instruction,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [acs_pkg::PC_W-1:0]     cfg_program_length,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [acs_pkg::PC_W-1:0]          out_next_pc,
  output logic [acs_pkg::DATA_W-1:0]        out_accumulator,
  output logic [acs_pkg::FLAG_W-1:0]        out_flag_bits,
  output logic                              out_mem_write,
  output logic [acs_pkg::MADDR_W-1:0]       out_mem_addr,
  output logic [acs_pkg::DATA_W-1:0]        out_mem_data,
  output logic                              out_led_write,
  output logic [acs_pkg::DATA_W-1:0]        out_led_column,
  output logic [acs_pkg::DATA_W-1:0]        out_led_row,
  output logic [acs_pkg::DATA_W-1:0]        out_led_color,
  output logic                              out_halted
);
  import acs_pkg::*;

  logic [PC_W-1:0] prog_len_r;
  dec_t            front_dec;
  dec_t            back_dec;
  logic            q_valid;
  logic            q_ready;

  // Program length register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prog_len_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      prog_len_r <= cfg_program_length;
    end
  end

  // Front: classify
  acs_decode u_decode (
    .instruction (in_instruction),
    .dec         (front_dec)
  );

  // Decoupling queue
  acs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (in_valid),
    .push_ready (in_ready),
    .push_data  (front_dec),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (back_dec)
  );

  // Back: execute and hold result
  acs_exec u_exec (
    .clk             (clk),
    .rst_n           (rst_n),
    .dec_valid       (q_valid),
    .dec_ready       (q_ready),
    .dec             (back_dec),
    .program_length  (prog_len_r),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_next_pc     (out_next_pc),
    .out_accumulator (out_accumulator),
    .out_flag_bits   (out_flag_bits),
    .out_mem_write   (out_mem_write),
    .out_mem_addr    (out_mem_addr),
    .out_mem_data    (out_mem_data),
    .out_led_write   (out_led_write),
    .out_led_column  (out_led_column),
    .out_led_row     (out_led_row),
    .out_led_color   (out_led_color),
    .out_halted      (out_halted)
  );

endmodule
`default_nettype wire

// File: tb/tb.sv
`default_nettype none
module tb;
  import acs_pkg::*;

  // Flag masks
  localparam logic [FLAG_W-1:0] FLG_EQ    = FLAG_W'(1) << F_EQ;
  localparam logic [FLAG_W-1:0] FLG_LT    = FLAG_W'(1) << F_LT;
  localparam logic [FLAG_W-1:0] FLG_GT    = FLAG_W'(1) << F_GT;
  localparam logic [FLAG_W-1:0] FLG_CARRY = FLAG_W'(1) << F_CARRY;
  localparam logic [FLAG_W-1:0] FLG_NZ    = FLAG_W'(1) << F_NZ;
  localparam logic [FLAG_W-1:0] FLG_SHIFT = FLAG_W'(1) << F_SHIFT;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int HOLD_CYCLES  = 200;
  localparam int TOTAL_ITEMS  = 1350;

  typedef struct packed {
    logic [PC_W-1:0]    next_pc;
    logic [DATA_W-1:0]  acc;
    logic [FLAG_W-1:0]  flags;
    logic               mem_write;
    logic [MADDR_W-1:0] mem_addr;
    logic [DATA_W-1:0]  mem_data;
    logic               led_write;
    logic [DATA_W-1:0]  led_column;
    logic [DATA_W-1:0]  led_row;
    logic [DATA_W-1:0]  led_color;
    logic               halted;
  } exec_result_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [INST_W-1:0]  in_instruction;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [PC_W-1:0]    cfg_program_length;
  logic               out_valid;
  logic               out_ready;
  logic [PC_W-1:0]    out_next_pc;
  logic [DATA_W-1:0]  out_accumulator;
  logic [FLAG_W-1:0]  out_flag_bits;
  logic               out_mem_write;
  logic [MADDR_W-1:0] out_mem_addr;
  logic [DATA_W-1:0]  out_mem_data;
  logic               out_led_write;
  logic [DATA_W-1:0]  out_led_column;
  logic [DATA_W-1:0]  out_led_row;
  logic [DATA_W-1:0]  out_led_color;
  logic               out_halted;

  accumulator_cpu_execute_step_core uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_instruction     (in_instruction),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_program_length (cfg_program_length),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_next_pc        (out_next_pc),
    .out_accumulator    (out_accumulator),
    .out_flag_bits      (out_flag_bits),
    .out_mem_write      (out_mem_write),
    .out_mem_addr       (out_mem_addr),
    .out_mem_data       (out_mem_data),
    .out_led_write      (out_led_write),
    .out_led_column     (out_led_column),
    .out_led_row        (out_led_row),
    .out_led_color      (out_led_color),
    .out_halted         (out_halted)
  );

  // Shadow machine state
  logic [PC_W-1:0]   shadow_pc = '0;
  logic [DATA_W-1:0] shadow_regs [16] = '{default: '0};
  logic [FLAG_W-1:0] shadow_flags = '0;
  logic [DATA_W-1:0] shadow_led_col = '0;
  logic [DATA_W-1:0] shadow_led_row = '0;
  logic [DATA_W-1:0] shadow_led_color = '0;
  logic [PC_W-1:0]   shadow_length = '0;

  exec_result_t pending_results [$];
  int  errors = 0;
  int  sent_count = 0;
  int  cycle_count = 0;
  bit  in_idle_on = 1'b1;
  bit  out_idle_on = 1'b1;
  bit  hold_req = 1'b0;

  // Clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Execute one instruction on the shadow state
  function automatic exec_result_t exec_inst(input logic [INST_W-1:0] inst);
    exec_result_t r;
    logic [3:0]        op;
    logic [3:0]        arg;
    logic [DATA_W-1:0] acc;
    logic [DATA_W-1:0] oth;
    logic [15:0]       addr;
    logic [8:0]        sum;
    logic [FLAG_W-1:0] f;
    op   = inst[7:4];
    arg  = inst[3:0];
    acc  = shadow_regs[0];
    oth  = shadow_regs[arg];
    addr = {shadow_regs[1], acc};
    r    = '0;
    shadow_pc = shadow_pc + 16'd1;
    case (op)
      OPC_LOADLO:  shadow_regs[0] = {acc[7:4], arg};
      OPC_LOADHI:  shadow_regs[0] = {arg, acc[3:0]};
      OPC_MOVTO:   shadow_regs[arg] = acc;
      OPC_MOVFROM: shadow_regs[0] = oth;
      OPC_ADD, OPC_SUB, OPC_SHR, OPC_AND, OPC_OR: begin
        // compare against the operand before the ALU result lands
        if (acc < oth) f = FLG_LT;
        else if (acc == oth) f = FLG_EQ;
        else f = FLG_GT;
        if (acc != '0) f = f | FLG_NZ;
        case (op)
          OPC_ADD: begin
            sum = {1'b0, acc} + {1'b0, oth};
            if (sum[8]) f = f | FLG_CARRY;
            shadow_regs[0] = sum[7:0];
          end
          OPC_SUB: shadow_regs[0] = acc - oth;
          OPC_SHR: begin
            if (acc[0]) f = f | FLG_SHIFT;
            shadow_regs[0] = acc >> 1;
          end
          OPC_AND: shadow_regs[0] = acc & oth;
          default: shadow_regs[0] = acc | oth;
        endcase
        shadow_flags = f;
      end
      OPC_JUMP: begin
        if ((arg & shadow_flags[3:0]) == arg) shadow_pc = addr;
      end
      OPC_STORE: begin
        if (!addr[15]) begin
          r.mem_write = 1'b1;
          r.mem_addr  = addr[14:0];
          r.mem_data  = oth;
        end else begin
          if (addr == LED_COL_ADDR) shadow_led_col = oth;
          else if (addr == LED_ROW_ADDR) shadow_led_row = oth;
          else if (addr == LED_COLOR_ADDR) shadow_led_color = oth;
          // full triple goes out and the latches clear
          if (shadow_led_col != '0 && shadow_led_row != '0 && shadow_led_color != '0) begin
            r.led_write  = 1'b1;
            r.led_column = shadow_led_col;
            r.led_row    = shadow_led_row;
            r.led_color  = shadow_led_color;
            shadow_led_col   = '0;
            shadow_led_row   = '0;
            shadow_led_color = '0;
          end
        end
      end
      default: ;
    endcase
    r.next_pc = shadow_pc;
    r.acc     = shadow_regs[0];
    r.flags   = shadow_flags;
    r.halted  = (shadow_pc >= shadow_length);
    return r;
  endfunction

  task automatic check_field(input string name, input logic [15:0] exp_v,
                             input logic [15:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, exp_v, act_v);
    end
  endtask

  // Monitor: config and input transfers feed the shadow, results are checked
  always @(posedge clk) begin : monitor
    exec_result_t want;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) shadow_length = cfg_program_length;
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none actual pc %h", $time,
                   out_next_pc);
        end else begin
          want = pending_results.pop_front();
          check_field("next_pc", want.next_pc, out_next_pc);
          check_field("accumulator", 16'(want.acc), 16'(out_accumulator));
          check_field("flag_bits", 16'(want.flags), 16'(out_flag_bits));
          check_field("mem_write", 16'(want.mem_write), 16'(out_mem_write));
          check_field("mem_addr", 16'(want.mem_addr), 16'(out_mem_addr));
          check_field("mem_data", 16'(want.mem_data), 16'(out_mem_data));
          check_field("led_write", 16'(want.led_write), 16'(out_led_write));
          check_field("led_column", 16'(want.led_column), 16'(out_led_column));
          check_field("led_row", 16'(want.led_row), 16'(out_led_row));
          check_field("led_color", 16'(want.led_color), 16'(out_led_color));
          check_field("halted", 16'(want.halted), 16'(out_halted));
        end
      end
      if (in_valid && in_ready) pending_results.push_back(exec_inst(in_instruction));
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("accumulator_cpu_execute_step_core regression: fail");
      $finish;
    end
  end

  // Result side: random stall bursts plus a long hold-off on request
  initial begin
    out_ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (out_idle_on && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Offer one instruction and wait for its transfer; valid stays up afterwards
  task automatic issue_inst(input logic [INST_W-1:0] inst);
    if (in_idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_instruction <= inst;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_count++;
  endtask

  task automatic issue_list(input logic [INST_W-1:0] prog [$]);
    foreach (prog[i]) issue_inst(prog[i]);
  endtask

  // Drop valid and let every outstanding result drain
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_length(input logic [PC_W-1:0] len);
    wait_idle();
    cfg_valid          <= 1'b1;
    cfg_program_length <= len;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Loads, moves, every ALU op with each compare outcome, unused opcodes
  task automatic test_alu_flags();
    write_length(16'h0000);
    issue_list('{{OPC_NOP, 4'h0}, {OPC_LOADHI, 4'hF}, {OPC_LOADLO, 4'hF},
                 {OPC_MOVTO, 4'h2}, {OPC_ADD, 4'h0}, {OPC_ADD, 4'hF},
                 {OPC_SHR, 4'h0}, {OPC_SHR, 4'h0}, {OPC_SUB, 4'h2},
                 {OPC_AND, 4'h2}, {OPC_OR, 4'h2}, {OPC_MOVFROM, 4'hE},
                 {OPC_SUB, 4'hE}, {OPC_SPARE_7, 4'hA}, {OPC_SPARE_D, 4'h0},
                 {OPC_SPARE_E, 4'hF}, {OPC_SPARE_F, 4'h5}});
  endtask

  // Always-jump to 0xFFFF, pc wrap to zero, taken and not-taken conditions
  task automatic test_jumps_wrap();
    write_length(16'hFFFF);
    issue_list('{{OPC_LOADHI, 4'hF}, {OPC_LOADLO, 4'hF}, {OPC_MOVTO, 4'h1},
                 {OPC_JUMP, 4'h0}, {OPC_SPARE_7, 4'h0}, {OPC_MOVFROM, 4'hE},
                 {OPC_SUB, 4'hE}, {OPC_JUMP, 4'h1}, {OPC_JUMP, 4'hF},
                 {OPC_ADD, 4'h0}, {OPC_JUMP, 4'h8}});
  endtask

  // Memory stores at the top of low memory, LED latches, store past the latches
  task automatic test_stores_led();
    write_length(16'h8000);
    issue_list('{{OPC_LOADHI, 4'h7}, {OPC_LOADLO, 4'hF}, {OPC_MOVTO, 4'h1},
                 {OPC_LOADHI, 4'hF}, {OPC_STORE, 4'h0}, {OPC_LOADHI, 4'h0},
                 {OPC_LOADLO, 4'h0}, {OPC_STORE, 4'h2}, {OPC_LOADHI, 4'h8},
                 {OPC_MOVTO, 4'h1}, {OPC_LOADHI, 4'h0}, {OPC_STORE, 4'h1},
                 {OPC_LOADLO, 4'h3}, {OPC_STORE, 4'h2}, {OPC_LOADLO, 4'h1},
                 {OPC_STORE, 4'h2}, {OPC_LOADLO, 4'h2}, {OPC_STORE, 4'h0}});
  endtask

  // One short well-formed sequence with random content, or raw noise
  task automatic send_random_block();
    int kind;
    logic [3:0] r;
    logic [3:0] alu_ops [5];
    alu_ops = '{OPC_ADD, OPC_SUB, OPC_SHR, OPC_AND, OPC_OR};
    kind = $urandom_range(0, 9);
    if (kind < 4) begin
      repeat ($urandom_range(1, 6)) issue_inst(INST_W'($urandom_range(0, 255)));
    end else if (kind < 7) begin
      // LED sequence: r1 = 0x80, then stores to random latch offsets
      issue_inst({OPC_LOADLO, 4'h0});
      issue_inst({OPC_LOADHI, 4'h8});
      issue_inst({OPC_MOVTO, 4'h1});
      repeat (4) begin
        r = 4'($urandom_range(2, 15));
        issue_inst({OPC_LOADHI, 4'($urandom_range(0, 15))});
        issue_inst({OPC_LOADLO, 4'($urandom_range(0, 15))});
        issue_inst({OPC_MOVTO, r});
        issue_inst({OPC_LOADHI, 4'h0});
        issue_inst({OPC_LOADLO, 4'($urandom_range(0, 3))});
        issue_inst({OPC_STORE, ($urandom_range(0, 7) == 0) ? 4'($urandom_range(0, 15)) : r});
      end
    end else begin
      // operand setup, ALU op, then a jump or a store
      r = 4'($urandom_range(2, 15));
      issue_inst({OPC_LOADHI, 4'($urandom_range(0, 15))});
      issue_inst({OPC_LOADLO, 4'($urandom_range(0, 15))});
      issue_inst({OPC_MOVTO, r});
      issue_inst({OPC_LOADHI, 4'($urandom_range(0, 15))});
      issue_inst({OPC_LOADLO, 4'($urandom_range(0, 15))});
      issue_inst({alu_ops[$urandom_range(0, 4)], r});
      if ($urandom_range(0, 1) == 0) issue_inst({OPC_JUMP, 4'($urandom_range(0, 15))});
      else issue_inst({OPC_STORE, 4'($urandom_range(0, 15))});
    end
  endtask

  task automatic test_random_programs(input int target, input bit with_idle);
    in_idle_on  = with_idle;
    out_idle_on = with_idle;
    while (sent_count < target) send_random_block();
  endtask

  // Receiver holds off while the sender keeps offering, filling the queue
  task automatic test_backpressure();
    in_idle_on = 1'b0;
    hold_req   = 1'b1;
    repeat (40) issue_inst(INST_W'($urandom_range(0, 255)));
    in_idle_on = 1'b1;
  endtask

  initial begin
    rst_n              <= 1'b0;
    in_valid           <= 1'b0;
    in_instruction     <= '0;
    cfg_valid          <= 1'b0;
    cfg_program_length <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_alu_flags();
    test_jumps_wrap();
    test_stores_led();
    write_length(16'($urandom_range(0, 16'hFFFF)));
    test_backpressure();
    write_length(16'hFFFF);
    test_random_programs(sent_count + 250, 1'b1);
    write_length(16'h0000);
    test_random_programs(sent_count + 250, 1'b1);
    write_length(16'($urandom_range(0, 16'hFFFF)));
    test_random_programs(sent_count + 250, 1'b1);
    write_length(16'($urandom_range(0, 64)));
    test_random_programs(sent_count + 250, 1'b1);
    write_length(16'($urandom_range(0, 16'hFFFF)));
    test_random_programs(TOTAL_ITEMS, 1'b0);

    wait_idle();
    repeat (10) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("accumulator_cpu_execute_step_core regression: pass");
    end else begin
      $display("accumulator_cpu_execute_step_core regression: fail");
    end
    $finish;
  end

endmodule
`default_nettype wire

// File: accumulator_cpu_execute_step_core.f
rtl/core/acs_pkg.sv
rtl/core/acs_decode.sv
rtl/core/acs_queue.sv
rtl/core/acs_exec.sv
rtl/core/accumulator_cpu_execute_step_core.sv
tb/tb.sv
